[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property macros for the RTL; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/evr_pkg.sv]
// ----------------------------------------------------------------------------
// Euler vector rotator package
// Types, register codes, sine table builder and rounding/saturation helper.
// ----------------------------------------------------------------------------
package evr_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [15:0] coef_t;
  typedef logic signed [47:0] prod_t;
  typedef logic signed [48:0] acc_t;
  typedef logic [15:0]        angle_t;
  typedef logic [14:0]        rom_word_t;

  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  localparam logic [2:0] COEF_CX = 3'd0;
  localparam logic [2:0] COEF_SX = 3'd1;
  localparam logic [2:0] COEF_CY = 3'd2;
  localparam logic [2:0] COEF_SY = 3'd3;
  localparam logic [2:0] COEF_CZ = 3'd4;
  localparam logic [2:0] COEF_SZ = 3'd5;
  localparam int unsigned NUM_COEF = 6;

  localparam coef_t     COEF_ONE    = 16'sd16384;
  localparam coef_t     COEF_ZERO   = 16'sd0;
  localparam rom_word_t ROM_ONE     = 15'd16384;
  localparam angle_t    QUARTER_TURN = 16'd16384;

  localparam int unsigned FRAC_BITS = 14;
  localparam acc_t        ACC_HALF  = 49'sd8192;
  localparam logic signed [34:0] SAT_HI = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] SAT_LO = 35'sh7_8000_0000;
  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [63:0] series_div(input logic [63:0] v, input int unsigned n);
    logic [63:0] r;
    unique case (n)
      1:       r = v / 64'd6;
      2:       r = v / 64'd20;
      3:       r = v / 64'd42;
      4:       r = v / 64'd72;
      5:       r = v / 64'd110;
      6:       r = v / 64'd156;
      7:       r = v / 64'd210;
      default: r = v / 64'd272;
    endcase
    return r;
  endfunction

  // Sine of (pi/2 * k / 2^bits) in Q1.14 by a truncated Taylor series in Q30.
  function automatic rom_word_t sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    int unsigned n;
    x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (bits - 1))) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (n = 1; n <= 8; n++) begin
      term = series_div((term * x2) >> 30, n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd32768) >> 16;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return v[14:0];
  endfunction

  // Round half up, arithmetic shift by the coefficient fraction, clamp to Q16.16.
  function automatic q16_t rnd_sat(input acc_t acc);
    acc_t                biased;
    logic signed [34:0]  shifted;
    q16_t                res;
    biased = acc + ACC_HALF;
    shifted = 35'(biased >>> FRAC_BITS);
    if (shifted > SAT_HI) begin
      res = Q16_MAX;
    end else if (shifted < SAT_LO) begin
      res = Q16_MIN;
    end else begin
      res = shifted[31:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/euler_xyz_vector_rotator_unit.sv]
// An input word passes six register stages, a multiply and a sum per axis, and
// its result is on out_tvalid. One word per cycle while out_tready is high, unless
// a register write stalls the input while the sine table refreshes.
// Reset (rst_n low, synchronous) clears the angles, the pipeline and the refresh.
// ----------------------------------------------------------------------------
// Euler X-Y-Z vector rotator
// Rotates a Q16.16 vector about X, then Y, then Z, with saturation per axis.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_xyz_vector_rotator_unit #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: in_x [31:0], in_y [63:32], in_z [95:64]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  // out_tdata: out_x [31:0], out_y [63:32], out_z [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned RomN = 1 << SINE_TABLE_BITS;
  localparam int unsigned IdxW = SINE_TABLE_BITS + 1;

  typedef evr_pkg::rom_word_t rom_t [RomN + 1];

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k <= RomN; k++) begin
      t[k] = evr_pkg::sine_entry(k, SINE_TABLE_BITS);
    end
    t[0] = '0;
    t[RomN] = evr_pkg::ROM_ONE;
    return t;
  endfunction

  localparam rom_t SinRom = build_rom();

  // Configuration registers
  evr_pkg::angle_t angle_x_r, angle_y_r, angle_z_r;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        evr_pkg::REG_ANGLE_X: angle_x_r <= cfg_pwdata[15:0];
        evr_pkg::REG_ANGLE_Y: angle_y_r <= cfg_pwdata[15:0];
        evr_pkg::REG_ANGLE_Z: angle_z_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      evr_pkg::REG_ANGLE_X: cfg_prdata = {16'd0, angle_x_r};
      evr_pkg::REG_ANGLE_Y: cfg_prdata = {16'd0, angle_y_r};
      evr_pkg::REG_ANGLE_Z: cfg_prdata = {16'd0, angle_z_r};
      default:              cfg_prdata = '0;
    endcase
  end

  localparam int unsigned NUM_COEF_L = evr_pkg::NUM_COEF;

  // Coefficient refresh: one table read per cycle, six coefficients.
  logic                busy_r, busy_nxt;
  logic [2:0]          step_r, step_nxt;
  logic                rq_vld_r;
  logic [2:0]          rq_step_r;
  logic                rq_neg_r;
  evr_pkg::rom_word_t  rq_val_r;
  evr_pkg::coef_t      coef_r [NUM_COEF_L];
  evr_pkg::angle_t     rd_ang;
  logic                rd_neg;
  logic [IdxW-1:0]     rd_idx;
  logic [SINE_TABLE_BITS-1:0] rd_frac;

  always_comb begin
    unique case (step_r[2:1])
      2'd0:    rd_ang = angle_x_r;
      2'd1:    rd_ang = angle_y_r;
      default: rd_ang = angle_z_r;
    endcase
    if (!step_r[0]) begin
      rd_ang = rd_ang + evr_pkg::QUARTER_TURN;
    end
    rd_frac = rd_ang[13 -: SINE_TABLE_BITS];
    rd_idx  = rd_ang[14] ? (IdxW'(RomN) - {1'b0, rd_frac}) : {1'b0, rd_frac};
    rd_neg  = rd_ang[15];
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (cfg_wr) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (step_r == 3'(NUM_COEF_L - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= '0;
      rq_vld_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      step_r   <= step_nxt;
      rq_vld_r <= busy_r && !cfg_wr;
    end
  end

  always_ff @(posedge clk) begin
    rq_step_r <= step_r;
    rq_neg_r  <= rd_neg;
    rq_val_r  <= SinRom[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[evr_pkg::COEF_CX] <= evr_pkg::COEF_ONE;
      coef_r[evr_pkg::COEF_SX] <= evr_pkg::COEF_ZERO;
      coef_r[evr_pkg::COEF_CY] <= evr_pkg::COEF_ONE;
      coef_r[evr_pkg::COEF_SY] <= evr_pkg::COEF_ZERO;
      coef_r[evr_pkg::COEF_CZ] <= evr_pkg::COEF_ONE;
      coef_r[evr_pkg::COEF_SZ] <= evr_pkg::COEF_ZERO;
    end else if (rq_vld_r) begin
      coef_r[rq_step_r] <= rq_neg_r ? -$signed({1'b0, rq_val_r}) : $signed({1'b0, rq_val_r});
    end
  end

  // Datapath pipeline: products, then round and saturate, for each axis.
  logic [6:1] vld_r;
  logic [6:1] rdy;
  logic       in_fire;

  always_comb begin
    rdy[6] = !vld_r[6] || out_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[1] && !busy_r && !rq_vld_r;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_fire;
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  evr_pkg::q16_t  in_x, in_y, in_z;
  evr_pkg::q16_t  s1_x_r, s2_x_r, s2_y_r, s2_z_r, s3_y_r, s4_x_r, s4_y_r, s4_z_r, s5_z_r;
  evr_pkg::q16_t  s6_x_r, s6_y_r, s6_z_r;
  evr_pkg::prod_t s1_pa_r, s1_pb_r, s1_pc_r, s1_pd_r;
  evr_pkg::prod_t s3_pa_r, s3_pb_r, s3_pc_r, s3_pd_r;
  evr_pkg::prod_t s5_pa_r, s5_pb_r, s5_pc_r, s5_pd_r;

  assign in_x = in_tdata[31:0];
  assign in_y = in_tdata[63:32];
  assign in_z = in_tdata[95:64];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r  <= in_x;
      s1_pa_r <= in_y * coef_r[evr_pkg::COEF_CX];
      s1_pb_r <= in_z * coef_r[evr_pkg::COEF_SX];
      s1_pc_r <= in_y * coef_r[evr_pkg::COEF_SX];
      s1_pd_r <= in_z * coef_r[evr_pkg::COEF_CX];
    end
    if (rdy[2] && vld_r[1]) begin
      s2_x_r <= s1_x_r;
      s2_y_r <= evr_pkg::rnd_sat(evr_pkg::acc_t'(s1_pa_r) - evr_pkg::acc_t'(s1_pb_r));
      s2_z_r <= evr_pkg::rnd_sat(evr_pkg::acc_t'(s1_pc_r) + evr_pkg::acc_t'(s1_pd_r));
    end
    if (rdy[3] && vld_r[2]) begin
      s3_y_r  <= s2_y_r;
      s3_pa_r <= s2_x_r * coef_r[evr_pkg::COEF_CY];
      s3_pb_r <= s2_z_r * coef_r[evr_pkg::COEF_SY];
      s3_pc_r <= s2_x_r * coef_r[evr_pkg::COEF_SY];
      s3_pd_r <= s2_z_r * coef_r[evr_pkg::COEF_CY];
    end
    if (rdy[4] && vld_r[3]) begin
      s4_y_r <= s3_y_r;
      s4_x_r <= evr_pkg::rnd_sat(evr_pkg::acc_t'(s3_pa_r) + evr_pkg::acc_t'(s3_pb_r));
      s4_z_r <= evr_pkg::rnd_sat(evr_pkg::acc_t'(s3_pd_r) - evr_pkg::acc_t'(s3_pc_r));
    end
    if (rdy[5] && vld_r[4]) begin
      s5_z_r  <= s4_z_r;
      s5_pa_r <= s4_x_r * coef_r[evr_pkg::COEF_CZ];
      s5_pb_r <= s4_y_r * coef_r[evr_pkg::COEF_SZ];
      s5_pc_r <= s4_x_r * coef_r[evr_pkg::COEF_SZ];
      s5_pd_r <= s4_y_r * coef_r[evr_pkg::COEF_CZ];
    end
    if (rdy[6] && vld_r[5]) begin
      s6_z_r <= s5_z_r;
      s6_x_r <= evr_pkg::rnd_sat(evr_pkg::acc_t'(s5_pa_r) - evr_pkg::acc_t'(s5_pb_r));
      s6_y_r <= evr_pkg::rnd_sat(evr_pkg::acc_t'(s5_pc_r) + evr_pkg::acc_t'(s5_pd_r));
    end
  end

  assign out_tvalid = vld_r[6];
  assign out_tdata  = {s6_z_r, s6_y_r, s6_x_r};

  `ASSERT_NXT(a_wr_blocks_input, clk, rst_n, cfg_wr, !in_tready)
  `ASSERT_IMP(a_refresh_tail, clk, rst_n, $fell(busy_r), rq_vld_r)
  `ASSERT_NXT(a_stage1_holds, clk, rst_n, vld_r[1] && !rdy[2], vld_r[1])

endmodule
